@@ rtl/blpn_pkg.sv @@
package blpn_pkg;

  localparam int MaxBuckets = 16;
  localparam int IdxW = 4;
  localparam logic [IdxW:0] MaxBucketsV = 5'd16;

  typedef enum logic [0:0] {
    CMD_ACCUM  = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    ST_NORM  = 1'b0,
    ST_RANGE = 1'b1
  } status_t;

  typedef enum logic [0:0] {
    REG_ORDER = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POW,
    S_ADD,
    S_ERR,
    S_RLOAD,
    S_RPOW,
    S_RCMP,
    S_ROUT,
    S_CLEAR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch input word, compute magnitude
    logic pow_init;   // product register to one
    logic pow_step;   // multiply product by base once
    logic sum_write;  // write saturated sum back to bucket
    logic root_load;  // fetch bucket sum, clear root
    logic cand_init;  // start a candidate: product to one, base to candidate
    logic root_keep;  // accept candidate if in range
    logic clear_sum;  // zero the bucket addressed by the slice counter
    logic [IdxW-1:0] slice;
  } dp_cmd_t;

endpackage

@@ rtl/blpn_if.sv @@
interface blpn_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [3:0]  bucket;
  logic signed [15:0] sample_value;
  modport source (output valid, command, bucket, sample_value, input ready);
  modport sink (input valid, command, bucket, sample_value, output ready);
endinterface

interface blpn_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [3:0]  slice_index;
  logic [63:0] norm_value;
  logic        last;
  modport source (output valid, status, slice_index, norm_value, last, input ready);
  modport sink (input valid, status, slice_index, norm_value, last, output ready);
endinterface

interface blpn_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/blpn_datapath.sv @@
module blpn_datapath
  import blpn_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  dp_cmd_t         cmd,
  input  logic [3:0]      bucket,
  input  logic [15:0]     sample,
  input  logic [5:0]      bit_idx,
  output logic [63:0]     root,
  output logic [63:0]     sum_val
);

  logic [63:0] sums_r [MaxBuckets];
  logic [31:0] base_r, base_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic        over_r, over_nxt;
  logic [63:0] acc_r;
  logic [31:0] root_r, root_nxt;
  logic [IdxW-1:0] bkt_r;
  logic [63:0]  mul_lo;
  logic [63:0]  mul_hi;
  logic [95:0]  mul;
  logic [64:0]  add;
  logic [31:0]  cand;

  // The base never exceeds 32 bits, so the product is built from two
  // 32x32 partial products.
  assign mul_lo = prod_r[31:0] * base_r;
  assign mul_hi = prod_r[63:32] * base_r;
  assign mul  = {mul_hi, 32'd0} + {32'd0, mul_lo};
  assign add  = {1'b0, sums_r[bkt_r]} + {1'b0, prod_r};
  assign cand = root_r | (32'd1 << bit_idx);

  always_comb begin
    prod_nxt = prod_r;
    over_nxt = over_r;
    base_nxt = base_r;
    root_nxt = root_r;
    if (cmd.capture) begin
      base_nxt = {15'd0, (sample[15] ? 17'(17'h10000 - {1'b0, sample}) : {1'b0, sample})};
    end
    if (cmd.pow_init) begin
      prod_nxt = 64'd1;
      over_nxt = 1'b0;
    end
    if (cmd.root_load) begin
      root_nxt = 32'd0;
    end
    if (cmd.cand_init) begin
      prod_nxt = 64'd1;
      over_nxt = 1'b0;
      base_nxt = cand;
    end
    if (cmd.pow_step && !over_r) begin
      if (mul[95:64] != 32'd0) begin
        over_nxt = 1'b1;
        prod_nxt = '1;
      end else begin
        prod_nxt = mul[63:0];
      end
    end
    if (cmd.root_keep && !over_r && prod_r <= acc_r) begin
      root_nxt = base_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxBuckets; i++) sums_r[i] <= '0;
    end else begin
      if (cmd.sum_write) sums_r[bkt_r] <= add[64] ? '1 : add[63:0];
      if (cmd.clear_sum) sums_r[cmd.slice] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    over_r <= over_nxt;
    base_r <= base_nxt;
    root_r <= root_nxt;
    if (cmd.capture) begin
      bkt_r <= bucket;
    end
    if (cmd.root_load) begin
      acc_r <= sums_r[cmd.slice];
      bkt_r <= cmd.slice;
    end
  end

  assign root    = {32'd0, root_r};
  assign sum_val = acc_r;

endmodule

@@ rtl/blpn_ctrl.sv @@
module blpn_ctrl
  import blpn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        in_command,
  input  logic [3:0]  in_bucket,
  input  logic [2:0]  order,
  input  logic [4:0]  count,
  input  logic        out_ready,
  output dp_cmd_t     cmd,
  output logic [5:0]  bit_idx,
  output logic        busy,
  output logic        out_valid,
  output logic        out_err,
  output logic        out_root,
  output logic        out_last,
  output logic [3:0]  out_slice
);

  state_t      state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [5:0]  bit_r, bit_nxt;
  logic [4:0]  slice_r, slice_nxt;
  logic [3:0]  ebkt_r, ebkt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      bit_r   <= '0;
      slice_r <= '0;
      ebkt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      bit_r   <= bit_nxt;
      slice_r <= slice_nxt;
      ebkt_r  <= ebkt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    bit_nxt   = bit_r;
    slice_nxt = slice_r;
    ebkt_nxt  = ebkt_r;
    cmd       = '0;
    cmd.slice = slice_r[IdxW-1:0];
    out_valid = 1'b0;
    out_err   = 1'b0;
    out_root  = 1'b0;
    out_last  = 1'b0;
    out_slice = slice_r[3:0];
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_command == CMD_FINISH) begin
            slice_nxt = '0;
            state_nxt = S_RLOAD;
          end else if ({1'b0, in_bucket} >= count) begin
            ebkt_nxt  = in_bucket;
            state_nxt = S_ERR;
          end else begin
            cmd.capture  = 1'b1;
            cmd.pow_init = 1'b1;
            step_nxt     = order;
            state_nxt    = S_POW;
          end
        end
      end
      S_POW: begin
        cmd.pow_step = 1'b1;
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd1) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.sum_write = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ERR: begin
        out_valid = 1'b1;
        out_err   = 1'b1;
        out_last  = 1'b1;
        out_slice = ebkt_r;
        if (out_ready) state_nxt = S_IDLE;
      end
      S_RLOAD: begin
        cmd.root_load = 1'b1;
        bit_nxt = 6'd31;
        state_nxt = (order == 3'd1) ? S_ROUT : S_RPOW;
        if (order != 3'd1) begin
          step_nxt = 3'd0;
        end
      end
      S_RPOW: begin
        if (step_r == 3'd0) begin
          cmd.cand_init = 1'b1;
          step_nxt = order;
        end else begin
          cmd.pow_step = 1'b1;
          step_nxt = step_r - 3'd1;
          if (step_r == 3'd1) state_nxt = S_RCMP;
        end
      end
      S_RCMP: begin
        cmd.root_keep = 1'b1;
        step_nxt = 3'd0;
        if (bit_r == 6'd0) state_nxt = S_ROUT;
        else begin
          bit_nxt = bit_r - 6'd1;
          state_nxt = S_RPOW;
        end
      end
      S_ROUT: begin
        out_valid = 1'b1;
        out_root  = (order != 3'd1);
        out_last  = (slice_r + 5'd1 == count);
        if (out_ready) begin
          if (slice_r + 5'd1 == count) begin
            slice_nxt = '0;
            state_nxt = S_CLEAR;
          end else begin
            slice_nxt = slice_r + 5'd1;
            state_nxt = S_RLOAD;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear_sum = 1'b1;
        slice_nxt = slice_r + 5'd1;
        if (slice_r == 5'(MaxBuckets - 1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign bit_idx = bit_r;

endmodule

@@ rtl/bucketed_lp_norm_unit.sv @@
// Per-slice Lp norm. An accumulate word runs one multiply per power step,
// each built from two 32x32 partial products with overflow detect; an
// out-of-range bucket returns one error word. A finish word walks every
// bucket in use with a 32-bit bitwise root search (none for L=1), each
// result waiting on any output stall, then clears all sums before the next
// word is accepted. One word is in flight at a time.
module bucketed_lp_norm_unit
  import blpn_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  blpn_in_if.sink   in_ch,
  blpn_out_if.source out_ch,
  blpn_cfg_if.sink  cfg_ch
);

  logic [2:0] order_r, order_nxt;
  logic [4:0] count_r, count_nxt;
  logic [4:0] count_use;
  dp_cmd_t    cmd;
  logic [5:0] bit_idx;
  logic       busy, ov, oerr, oroot, olast;
  logic [3:0] oslice;
  logic [63:0] root, sum_val;
  logic       in_fire;

  assign count_use = (count_r > MaxBucketsV) ? MaxBucketsV : count_r;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    order_nxt = order_r;
    count_nxt = count_r;
    if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_ORDER) begin
        if (cfg_ch.data[2:0] != 3'd0)
          order_nxt = (cfg_ch.data[2:0] > 3'd4) ? 3'd4 : cfg_ch.data[2:0];
      end else begin
        count_nxt = (cfg_ch.data[4:0] == 5'd0) ? 5'd1 : cfg_ch.data[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 3'd2;
      count_r <= 5'd16;
    end else begin
      order_r <= order_nxt;
      count_r <= count_nxt;
    end
  end

  blpn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_command(in_ch.command),
    .in_bucket(in_ch.bucket), .order(order_r), .count(count_use),
    .out_ready(out_ch.ready), .cmd(cmd), .bit_idx(bit_idx),
    .busy(busy), .out_valid(ov), .out_err(oerr), .out_root(oroot),
    .out_last(olast), .out_slice(oslice)
  );

  blpn_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .bucket(in_ch.bucket),
    .sample(in_ch.sample_value), .bit_idx(bit_idx),
    .root(root), .sum_val(sum_val)
  );

  assign out_ch.valid       = ov;
  assign out_ch.status      = oerr ? ST_RANGE : ST_NORM;
  assign out_ch.slice_index = oslice;
  assign out_ch.norm_value  = oerr ? 64'd0 : (oroot ? root : sum_val);
  assign out_ch.last        = olast;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> out_ch.norm_value == 64'd0 && out_ch.last)
    else $error("error word malformed");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped");

endmodule
